// File: design/can_id_dispatch_table_defines.svh
// ----------------------------------------------------------------------------
// CAN ID dispatch table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAN_ID_DISPATCH_TABLE_DEFINES_SVH
`define CAN_ID_DISPATCH_TABLE_DEFINES_SVH

// Same-cycle implication
`define CIDT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispatch table check failed");

// Next-cycle implication
`define CIDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispatch table sequencing check failed");

`endif

// File: design/cidt_pkg.sv
// ----------------------------------------------------------------------------
// CAN ID dispatch table package
// Field widths, result status codes, sequencer states and RAM control type.
// ----------------------------------------------------------------------------
package cidt_pkg;

    localparam int SLOTS_DEFAULT = 20;
    localparam int BUCKETS       = 4;

    localparam int ID_W     = 29;
    localparam int TAG_W    = 8;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = ID_W + TAG_W;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_REGISTERED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MATCH      = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOMATCH    = 2'd3;

    // Input mode codes
    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_RECEIVE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REG,
        ST_RD,
        ST_CMP,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

// File: design/cidt_slot_ram.sv
// ----------------------------------------------------------------------------
// CAN ID dispatch table slot RAM
// Single-port entry store with a registered read word.
// ----------------------------------------------------------------------------
module cidt_slot_ram #(
    parameter int DEPTH = 4 * cidt_pkg::SLOTS_DEFAULT
) (
    input  logic                             clk,
    input  cidt_pkg::mem_ctl_t               ctl,
    input  logic [$clog2(DEPTH)-1:0]         addr,
    input  logic [cidt_pkg::ENTRY_W-1:0]     wr_data,
    output logic [cidt_pkg::ENTRY_W-1:0]     rd_data
);
    import cidt_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];

    // Write an entry
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // Read an entry, hold the word until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

// File: design/can_id_dispatch_table.sv
// ----------------------------------------------------------------------------
// CAN ID dispatch table
// Four buckets of handler entries (bus x identifier kind), appended by
// register words and walked slot by slot by receive words.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one word per item; mode 0 registers frame_id and
//   handler_tag in bucket {bus, extended}, mode 1 looks up a received frame.
//   Result channel (rsp_*): register words give one result (registered or
//   bucket full); receive words give one match result per matching filled
//   slot in slot order, or one no-match result. last marks the final result.
//   A register word loads its result from ST_REG once the result register
//   can take it. A receive word walks its bucket through one shared compare
//   and the slot RAM read port, slot by slot via ST_RD and ST_CMP, to ST_FIN.
//   req_stall stays high from acceptance until the final result is loaded.
//   One matching result is held back so that last can be set on the final
//   one. A stalled valid result is held; the walk waits only to load another.
//   Reset empties all buckets; the slot RAM itself is not cleared, since only
//   filled slots are ever read.
// ----------------------------------------------------------------------------
`include "can_id_dispatch_table_defines.svh"

module can_id_dispatch_table #(
    parameter int SLOTS = cidt_pkg::SLOTS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              mode,
    input  logic                              bus,
    input  logic                              extended,
    input  logic [cidt_pkg::ID_W-1:0]         frame_id,
    input  logic [cidt_pkg::TAG_W-1:0]        handler_tag,
    // result channel
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [cidt_pkg::STATUS_W-1:0]     status,
    output logic [cidt_pkg::TAG_W-1:0]        matched_handler,
    output logic [cidt_pkg::SLOT_W-1:0]       slot_index,
    output logic                              last
);
    import cidt_pkg::*;

    localparam int DEPTH  = BUCKETS * SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(SLOTS + 1);

    state_t state_reg, state_next;

    logic               mode_reg;
    logic [1:0]         bucket_reg;
    logic [ID_W-1:0]    id_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [FILL_W-1:0]  idx_reg;
    logic [FILL_W-1:0]  fill_reg [BUCKETS];
    logic [FILL_W-1:0]  fill_cur;
    logic               bucket_full;

    logic               pend_valid_reg;
    logic [TAG_W-1:0]   pend_tag_reg;
    logic [FILL_W-1:0]  pend_slot_reg;

    logic               out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [TAG_W-1:0]   out_handler_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_last_reg;

    mem_ctl_t           mem_ctl;
    logic [ADDR_W-1:0]  mem_addr;
    logic [FILL_W-1:0]  mem_idx;
    logic [ENTRY_W-1:0] rd_data;
    logic [ID_W-1:0]    rd_id;
    logic [TAG_W-1:0]   rd_tag;
    logic               hit;

    logic               accept;
    logic               can_load;
    logic               out_load;
    logic [STATUS_W-1:0] out_status;
    logic [TAG_W-1:0]   out_handler;
    logic [FILL_W-1:0]  out_slot;
    logic               out_last;
    logic               idx_inc;
    logic               pend_load;
    logic               fill_inc;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign can_load  = !out_valid_reg || !rsp_stall;

    assign fill_cur    = fill_reg[bucket_reg];
    assign bucket_full = (fill_cur >= FILL_W'(SLOTS));

    assign rd_id  = rd_data[ENTRY_W-1:TAG_W];
    assign rd_tag = rd_data[TAG_W-1:0];
    assign hit    = (rd_id == '0) || (rd_id == id_reg);

    // Slot address: bucket base plus slot number
    assign mem_idx  = (state_reg == ST_REG) ? fill_cur : idx_reg;
    assign mem_addr = ADDR_W'(ADDR_W'(bucket_reg) * ADDR_W'(SLOTS)) + ADDR_W'(mem_idx);

    cidt_slot_ram #(
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .ctl     (mem_ctl),
        .addr    (mem_addr),
        .wr_data ({id_reg, tag_reg}),
        .rd_data (rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (mode == MODE_REGISTER) ? ST_REG : ST_RD;
                end
            end
            ST_REG:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = (idx_reg == fill_cur) ? ST_FIN : ST_CMP;
            end
            ST_CMP:
            begin
                if (!(hit && pend_valid_reg) || can_load)
                begin
                    state_next = ST_RD;
                end
            end
            ST_FIN:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        mem_ctl     = '0;
        out_load    = 1'b0;
        out_status  = STATUS_REGISTERED;
        out_handler = '0;
        out_slot    = '0;
        out_last    = 1'b1;
        idx_inc     = 1'b0;
        pend_load   = 1'b0;
        fill_inc    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_REG:
            begin
                if (can_load)
                begin
                    out_load = 1'b1;
                    if (bucket_full)
                    begin
                        out_status = STATUS_FULL;
                    end
                    else
                    begin
                        mem_ctl.wr_en = 1'b1;
                        fill_inc      = 1'b1;
                        out_slot      = fill_cur;
                    end
                end
            end
            ST_RD:
            begin
                mem_ctl.rd_en = (idx_reg != fill_cur);
            end
            ST_CMP:
            begin
                if (hit && pend_valid_reg)
                begin
                    if (can_load)
                    begin
                        out_load    = 1'b1;
                        out_status  = STATUS_MATCH;
                        out_handler = pend_tag_reg;
                        out_slot    = pend_slot_reg;
                        out_last    = 1'b0;
                        pend_load   = 1'b1;
                        idx_inc     = 1'b1;
                    end
                end
                else
                begin
                    pend_load = hit;
                    idx_inc   = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (can_load)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_status  = STATUS_MATCH;
                        out_handler = pend_tag_reg;
                        out_slot    = pend_slot_reg;
                    end
                    else
                    begin
                        out_status = STATUS_NOMATCH;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Advance sequencer and walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                pend_valid_reg <= 1'b0;
                idx_reg        <= '0;
            end
            else
            begin
                if (pend_load)
                begin
                    pend_valid_reg <= 1'b1;
                end
                if (idx_inc)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    // Count filled slots per bucket
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BUCKETS; b++)
            begin
                fill_reg[b] <= '0;
            end
        end
        else if (fill_inc)
        begin
            fill_reg[bucket_reg] <= fill_cur + 1'b1;
        end
    end

    // Capture the request word and the held-back match
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            bucket_reg <= {bus, extended};
            id_reg     <= frame_id;
            tag_reg    <= handler_tag;
        end
        if (pend_load)
        begin
            pend_tag_reg  <= rd_tag;
            pend_slot_reg <= idx_reg;
        end
    end

    // Result register valid: load, or drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg  <= out_status;
            out_handler_reg <= out_handler;
            out_slot_reg    <= SLOT_W'(out_slot);
            out_last_reg    <= out_last;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign matched_handler = out_handler_reg;
    assign slot_index      = out_slot_reg;
    assign last            = out_last_reg;

    `CIDT_ASSERT_SAME(a_fill_bound, state_reg != ST_IDLE, fill_cur <= FILL_W'(SLOTS))
    `CIDT_ASSERT_SAME(a_cmp_in_range, state_reg == ST_CMP, idx_reg < fill_cur)
    `CIDT_ASSERT_SAME(a_write_only_reg, mem_ctl.wr_en,
        state_reg == ST_REG && mode_reg == MODE_REGISTER && !bucket_full)
    `CIDT_ASSERT_SAME(a_single_result_last,
        out_valid_reg && out_status_reg != STATUS_MATCH, out_last_reg)
    `CIDT_ASSERT_SAME(a_no_load_over_stalled, out_valid_reg && rsp_stall, !out_load)
    `CIDT_ASSERT_NEXT(a_accept_busy, accept, state_reg != ST_IDLE)

endmodule

// File: bench/can_id_dispatch_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN ID dispatch table checker
// Watches the request and result channels of the dispatch table, keeps its
// own copy of the four handler buckets, predicts the results of every
// accepted request word and compares each accepted result word, field by
// field, with the oldest prediction still owed.
// ----------------------------------------------------------------------------
module can_id_dispatch_table_checker
    import cidt_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                req_valid,
    input  logic                req_stall,
    input  logic                mode,
    input  logic                bus,
    input  logic                extended,
    input  logic [ID_W-1:0]     frame_id,
    input  logic [TAG_W-1:0]    handler_tag,
    // result channel
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [TAG_W-1:0]    matched_handler,
    input  logic [SLOT_W-1:0]   slot_index,
    input  logic                last,
    // verdict inputs for the bench top
    output int                  mismatch_count,
    output int                  results_outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    handler;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } dispatch_result_t;

    dispatch_result_t  owed_results [$];
    logic [ID_W-1:0]   entry_ids    [BUCKETS][SLOTS];
    logic [TAG_W-1:0]  entry_tags   [BUCKETS][SLOTS];
    int unsigned       entries_used [BUCKETS];

    // Append or look up one request word and queue the results it causes
    function automatic void predict_dispatch(logic word_mode, logic word_bus,
                                             logic word_ext,
                                             logic [ID_W-1:0] word_id,
                                             logic [TAG_W-1:0] word_tag);
        int unsigned      bkt;
        int unsigned      used;
        int               hits;
        int               i;
        dispatch_result_t r;
        bkt  = {word_bus, word_ext};
        used = entries_used[bkt];
        if (word_mode == MODE_REGISTER) begin
            if (used >= SLOTS) begin
                r = '{STATUS_FULL, '0, '0, 1'b1};
            end
            else begin
                entry_ids[bkt][used]  = word_id;
                entry_tags[bkt][used] = word_tag;
                entries_used[bkt]     = used + 1;
                r = '{STATUS_REGISTERED, '0, SLOT_W'(used), 1'b1};
            end
            owed_results.push_back(r);
            return;
        end
        // walk filled slots in order; a stored zero accepts every frame
        hits = 0;
        for (i = 0; i < used; i++) begin
            if (entry_ids[bkt][i] == '0 || entry_ids[bkt][i] == word_id) begin
                r = '{STATUS_MATCH, entry_tags[bkt][i], SLOT_W'(i), 1'b0};
                owed_results.push_back(r);
                hits++;
            end
        end
        if (hits == 0) begin
            r = '{STATUS_NOMATCH, '0, '0, 1'b1};
            owed_results.push_back(r);
        end
        else begin
            owed_results[owed_results.size()-1].last = 1'b1;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Sample both channels at the rising edge
    always @(posedge clk or negedge rst_n) begin
        dispatch_result_t want;
        if (!rst_n) begin
            owed_results.delete();
            for (int b = 0; b < BUCKETS; b++) begin
                entries_used[b] = 0;
            end
            results_outstanding = 0;
        end
        else begin
            if (req_valid && !req_stall) begin
                predict_dispatch(mode, bus, extended, frame_id, handler_tag);
            end
            if (rsp_valid && !rsp_stall) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result word: status %0d slot %0d",
                           status, slot_index);
                    mismatch_count++;
                end
                else begin
                    want = owed_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("matched_handler", want.handler, matched_handler);
                    check_field("slot_index", want.slot, slot_index);
                    check_field("last", want.last, last);
                end
            end
            results_outstanding = owed_results.size();
        end
    end

endmodule

// File: bench/can_id_dispatch_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN ID dispatch table bench top
// Drives register and receive words into the dispatch table: a directed run
// over empty, wildcard, unmasked-identifier and full-bucket cases, then
// random words in three idling phases with a long result hold-off. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module can_id_dispatch_table_test;

    import cidt_pkg::*;

    localparam int SLOTS          = SLOTS_DEFAULT;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 2 * SLOTS + 10;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic                mode;
    logic                bus;
    logic                extended;
    logic [ID_W-1:0]     frame_id;
    logic [TAG_W-1:0]    handler_tag;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    matched_handler;
    logic [SLOT_W-1:0]   slot_index;
    logic                last;

    int                  mismatch_count;
    int                  results_outstanding;
    int                  send_idle_pct = 0;
    int                  rsp_idle_pct  = 0;
    logic                hold_off_req  = 1'b0;
    int                  quiet_cycles  = 0;
    logic [ID_W-1:0]     known_ids [BUCKETS][$];

    always #2 clk = ~clk;

    can_id_dispatch_table #(
        .SLOTS(SLOTS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .mode            (mode),
        .bus             (bus),
        .extended        (extended),
        .frame_id        (frame_id),
        .handler_tag     (handler_tag),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .matched_handler (matched_handler),
        .slot_index      (slot_index),
        .last            (last)
    );

    can_id_dispatch_table_checker #(
        .SLOTS(SLOTS)
    ) dispatch_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .req_valid           (req_valid),
        .req_stall           (req_stall),
        .mode                (mode),
        .bus                 (bus),
        .extended            (extended),
        .frame_id            (frame_id),
        .handler_tag         (handler_tag),
        .rsp_valid           (rsp_valid),
        .rsp_stall           (rsp_stall),
        .status              (status),
        .matched_handler     (matched_handler),
        .slot_index          (slot_index),
        .last                (last),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    // Stall results at random, or hold them off for a long stretch on request
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
        end
    end

    // End the run when no word moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Offer one request word after random idle cycles; return at a falling
    // edge once it is accepted, with valid left high
    task automatic send_word(logic m, logic b, logic e, logic [ID_W-1:0] id,
                             logic [TAG_W-1:0] tag);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        mode        <= m;
        bus         <= b;
        extended    <= e;
        frame_id    <= id;
        handler_tag <= tag;
        if (m == MODE_REGISTER) begin
            known_ids[{b, e}].push_back(id);
        end
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Build a random word; receive words mostly reuse known identifiers so lookups hit
    task automatic send_random_word();
        logic            m;
        logic [ID_W-1:0] id;
        int unsigned     bkt;
        int unsigned     pick;
        int              n;
        m    = ($urandom_range(0, 99) < 45) ? MODE_REGISTER : MODE_RECEIVE;
        bkt  = $urandom_range(0, BUCKETS - 1);
        pick = $urandom_range(0, 99);
        n    = known_ids[bkt].size();
        if (pick[0]) begin
            id = ID_W'($urandom_range(0, 2047));
        end
        else begin
            id = ID_W'($urandom());
        end
        if (m == MODE_REGISTER) begin
            if (pick < 15) begin
                id = '0;
            end
            else if (pick < 50 && n > 0) begin
                id = known_ids[bkt][$urandom_range(0, n - 1)];
            end
        end
        else begin
            if (pick < 65 && n > 0) begin
                id = known_ids[bkt][$urandom_range(0, n - 1)];
            end
            else if (pick < 72) begin
                id = '0;
            end
        end
        send_word(m, bkt[1], bkt[0], id, TAG_W'($urandom_range(0, 255)));
    endtask

    // Drop valid and hold the sender until every owed result has been accepted
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (results_outstanding != 0) @(negedge clk);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        mode        = MODE_REGISTER;
        bus         = 1'b0;
        extended    = 1'b0;
        frame_id    = '0;
        handler_tag = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 29;
        rsp_idle_pct  = 60;

        // lookup in an empty bucket
        send_word(MODE_RECEIVE, 1'b0, 1'b0, 29'h1FFF_FFFF, 8'hFF);
        // exact entry and wildcard in the same bucket, both hit
        send_word(MODE_REGISTER, 1'b0, 1'b0, 29'h1FFF_FFFF, 8'hFF);
        send_word(MODE_REGISTER, 1'b0, 1'b0, 29'h0, 8'h00);
        send_word(MODE_RECEIVE, 1'b0, 1'b0, 29'h1FFF_FFFF, 8'h00);
        // standard identifiers compare all 29 bits
        send_word(MODE_REGISTER, 1'b1, 1'b0, 29'h1000_0123, 8'h5A);
        send_word(MODE_RECEIVE, 1'b1, 1'b0, 29'h0000_0123, 8'h00);
        send_word(MODE_RECEIVE, 1'b1, 1'b0, 29'h1000_0123, 8'hA5);
        // fill one bucket, overflow it, then hit every slot at once
        for (int i = 0; i < SLOTS; i++) begin
            send_word(MODE_REGISTER, 1'b1, 1'b1, (i % 3 == 0) ? 29'h0 : 29'h0ABC_DEF,
                      TAG_W'(8'hF0 ^ i));
        end
        send_word(MODE_REGISTER, 1'b1, 1'b1, 29'h0ABC_DEF, 8'h33);
        send_word(MODE_RECEIVE, 1'b1, 1'b1, 29'h0ABC_DEF, 8'h00);

        // keep offering words while results are held off
        wait_for_results();
        hold_off_req = 1'b1;
        repeat (8) send_random_word();
        wait_for_results();

        repeat (21) send_random_word();
        wait_for_results();

        send_idle_pct = 60;
        rsp_idle_pct  = 29;
        repeat (21) send_random_word();
        wait_for_results();

        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        repeat (21) send_random_word();

        // drain, then give stray results time to show
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && results_outstanding == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/cidt_pkg.sv
design/cidt_slot_ram.sv
design/can_id_dispatch_table.sv
bench/can_id_dispatch_table_checker.sv
bench/can_id_dispatch_table_test.sv
